@@ hdl/cubic_mean_ratio_tet_quality_defines.svh @@
// assertion macros for the tetrahedron quality block
`ifndef CUBIC_MEAN_RATIO_TET_QUALITY_DEFINES_SVH
`define CUBIC_MEAN_RATIO_TET_QUALITY_DEFINES_SVH

// same-cycle implication, checked on clock, off during reset
`define CMR_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cmr check failed");

// next-cycle implication, checked on clock, off during reset
`define CMR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cmr check failed");

`endif

@@ hdl/cmr_pkg.sv @@
// shared constants and types for the tetrahedron quality block
package cmr_pkg;

   localparam int COORD_WIDTH_DEF       = 16;
   localparam int QUALITY_FRAC_BITS_DEF = 30;
   localparam int QUALITY_WIDTH         = 32;

   // chunk width of the split multipliers
   localparam int MUL_CHUNK = 24;
   // register stages in the geometry front end and in each split multiplier
   localparam int FRONT_LAT = 5;
   localparam int MUL_LAT   = 3;

   // 432 fits in this many bits
   localparam int SCALE_BITS = 9;

   localparam logic [QUALITY_WIDTH-1:0] MAX_MAG = {1'b0, {(QUALITY_WIDTH-1){1'b1}}};

   // every point pair as an edge, the edges from point 0 come first
   localparam int EDGE_FROM [6] = '{0, 0, 0, 1, 1, 2};
   localparam int EDGE_TO   [6] = '{1, 2, 3, 2, 3, 3};

   // cyclic axis neighbors for the cross product
   localparam int AXIS_NEXT [3] = '{1, 2, 0};
   localparam int AXIS_PREV [3] = '{2, 0, 1};

   typedef struct packed {
      logic neg;
      logic degen;
   } cmr_tag_type;

endpackage

@@ hdl/cmr_if.sv @@
// request and response channel interfaces
interface cmr_req_if #(
   parameter int COORD_WIDTH = cmr_pkg::COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] x0, y0, z0;
   logic signed [COORD_WIDTH-1:0] x1, y1, z1;
   logic signed [COORD_WIDTH-1:0] x2, y2, z2;
   logic signed [COORD_WIDTH-1:0] x3, y3, z3;

   modport source (
      output valid, x0, y0, z0, x1, y1, z1, x2, y2, z2, x3, y3, z3,
      input  ready
   );
   modport sink (
      input  valid, x0, y0, z0, x1, y1, z1, x2, y2, z2, x3, y3, z3,
      output ready
   );
endinterface

interface cmr_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [cmr_pkg::QUALITY_WIDTH-1:0] quality;
   logic                                      degenerate;

   modport source (output valid, quality, degenerate, input ready);
   modport sink (input valid, quality, degenerate, output ready);
endinterface

@@ hdl/cubic_mean_ratio_tet_quality.sv @@
// top level: signed cubic mean ratio of one tetrahedron per request
//
//   channel   direction  payload
//   req_chan  in         x0..z3, four points, COORD_WIDTH bits signed
//   rsp_chan  out        quality (signed Q1.QUALITY_FRAC_BITS), degenerate
//
// one request per cycle while no response is held; the pipeline has
// 5 geometry stages, 1 abs stage, two chained 3-stage split multipliers for
// the cube of the edge sum, 32 one-bit division stages and 1 output stage.
// reset clears only the valid bits; data registers are not reset.
// when a response is held, the whole pipeline freezes and req_chan.ready drops.
`include "cubic_mean_ratio_tet_quality_defines.svh"

module cubic_mean_ratio_tet_quality #(
   parameter int COORD_WIDTH       = cmr_pkg::COORD_WIDTH_DEF,
   parameter int QUALITY_FRAC_BITS = cmr_pkg::QUALITY_FRAC_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   cmr_req_if.sink   req_chan,
   cmr_rsp_if.source rsp_chan
);
   import cmr_pkg::*;

   localparam int DW   = 3 * COORD_WIDTH + 6;
   localparam int LW   = 2 * COORD_WIDTH + 7;
   localparam int L2W  = 2 * LW;
   localparam int L3W  = 3 * LW;
   localparam int D2W  = 2 * DW;
   localparam int NUMW = D2W + SCALE_BITS + QUALITY_FRAC_BITS;
   localparam int RW   = (NUMW > L3W + QUALITY_WIDTH) ? NUMW : L3W + QUALITY_WIDTH;
   localparam int QW   = QUALITY_WIDTH;
   localparam int LAT  = FRONT_LAT + 1 + 2 * MUL_LAT + QW + 1;

   logic                          pipe_en;
   logic [LAT-1:0]                vld_ff;
   logic signed [COORD_WIDTH-1:0] pt [4][3];
   logic signed [DW-1:0]          d;
   logic [LW-1:0]                 l;

   logic [DW-1:0]                 dabs_ff;
   logic [LW-1:0]                 l6_ff;
   cmr_tag_type                   tag6_ff;
   logic [LW-1:0]                 ldly_ff [MUL_LAT];
   cmr_tag_type                   tag_dly_ff [2*MUL_LAT];
   logic [D2W-1:0]                d2;
   logic [L2W-1:0]                l2;
   logic [L3W-1:0]                l3;
   logic [NUMW-1:0]               num_in;
   logic [NUMW-1:0]               num_dly_ff [MUL_LAT];

   logic [RW-1:0]                 rem_w [QW+1];
   logic [L3W-1:0]                den_w [QW+1];
   logic [QW-1:0]                 quo_w [QW+1];
   cmr_tag_type                   tag_w [QW+1];

   logic [QW-1:0]                 mag;
   logic [QW-1:0]                 quality_in;
   logic                          degen_in;
   logic [QW-1:0]                 quality_ff;
   logic                          degen_ff;

   // pipeline advances unless a finished response is held
   assign pipe_en        = rsp_chan.ready | ~vld_ff[LAT-1];
   assign req_chan.ready = pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_chan.valid};
      end
   end

   // request fields as a point array
   assign pt[0][0] = req_chan.x0;
   assign pt[0][1] = req_chan.y0;
   assign pt[0][2] = req_chan.z0;
   assign pt[1][0] = req_chan.x1;
   assign pt[1][1] = req_chan.y1;
   assign pt[1][2] = req_chan.z1;
   assign pt[2][0] = req_chan.x2;
   assign pt[2][1] = req_chan.y2;
   assign pt[2][2] = req_chan.z2;
   assign pt[3][0] = req_chan.x3;
   assign pt[3][1] = req_chan.y3;
   assign pt[3][2] = req_chan.z3;

   cmr_front #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_front (
      .clock (clock),
      .en    (pipe_en),
      .pt    (pt),
      .d     (d),
      .l     (l)
   );

   // magnitude, sign and coincident-point flag
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         dabs_ff       <= d[DW-1] ? DW'(-d) : DW'(d);
         l6_ff         <= l;
         tag6_ff.neg   <= d[DW-1];
         tag6_ff.degen <= (l == '0);
      end
   end

   // squares of volume and edge sum
   cmr_wide_mul #(.A_W(DW), .B_W(DW)) u_mul_d2 (
      .clock (clock),
      .en    (pipe_en),
      .a     (dabs_ff),
      .b     (dabs_ff),
      .p     (d2)
   );

   cmr_wide_mul #(.A_W(LW), .B_W(LW)) u_mul_l2 (
      .clock (clock),
      .en    (pipe_en),
      .a     (l6_ff),
      .b     (l6_ff),
      .p     (l2)
   );

   // edge sum held to meet its square
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         ldly_ff[0] <= l6_ff;
         for (int i = 1; i < MUL_LAT; i++) begin
            ldly_ff[i] <= ldly_ff[i-1];
         end
      end
   end

   // cube of the edge sum is the divisor
   cmr_wide_mul #(.A_W(L2W), .B_W(LW)) u_mul_l3 (
      .clock (clock),
      .en    (pipe_en),
      .a     (l2),
      .b     (ldly_ff[MUL_LAT-1]),
      .p     (l3)
   );

   // dividend: 432 = 256 + 128 + 32 + 16, then the fraction shift
   assign num_in = ((NUMW'(d2) << 8) + (NUMW'(d2) << 7) + (NUMW'(d2) << 5)
                    + (NUMW'(d2) << 4)) << QUALITY_FRAC_BITS;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         num_dly_ff[0] <= num_in;
         for (int i = 1; i < MUL_LAT; i++) begin
            num_dly_ff[i] <= num_dly_ff[i-1];
         end
         tag_dly_ff[0] <= tag6_ff;
         for (int i = 1; i < 2 * MUL_LAT; i++) begin
            tag_dly_ff[i] <= tag_dly_ff[i-1];
         end
      end
   end

   // long division, top bit flags saturation
   assign rem_w[0] = RW'(num_dly_ff[MUL_LAT-1]);
   assign den_w[0] = l3;
   assign quo_w[0] = '0;
   assign tag_w[0] = tag_dly_ff[2*MUL_LAT-1];

   for (genvar s = 0; s < QW; s++) begin : g_div
      cmr_div_stage #(
         .REM_W (RW),
         .DEN_W (L3W),
         .SHIFT (QW - 1 - s)
      ) u_stage (
         .clock   (clock),
         .en      (pipe_en),
         .src_rem (rem_w[s]),
         .src_den (den_w[s]),
         .src_quo (quo_w[s]),
         .src_tag (tag_w[s]),
         .dst_rem (rem_w[s+1]),
         .dst_den (den_w[s+1]),
         .dst_quo (quo_w[s+1]),
         .dst_tag (tag_w[s+1])
      );
   end

   // saturate, apply sign, force zero for coincident points
   always_comb begin
      mag = quo_w[QW][QW-1] ? MAX_MAG : {1'b0, quo_w[QW][QW-2:0]};
      if (tag_w[QW].degen) begin
         quality_in = '0;
         degen_in   = 1'b1;
      end else begin
         quality_in = tag_w[QW].neg ? QW'(-mag) : mag;
         degen_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         quality_ff <= quality_in;
         degen_ff   <= degen_in;
      end
   end

   assign rsp_chan.valid      = vld_ff[LAT-1];
   assign rsp_chan.quality    = quality_ff;
   assign rsp_chan.degenerate = degen_ff;

   // a held response freezes every valid bit
   `CMR_ASSERT_NEXT(a_stall_freeze, !pipe_en, vld_ff == $past(vld_ff))
   // the coincident flag stays aligned with a zero divisor
   `CMR_ASSERT_SAME(a_degen_align, vld_ff[LAT-2], (den_w[QW] == '0) == tag_w[QW].degen)
   // an unsaturated quotient leaves a remainder below the divisor
   `CMR_ASSERT_SAME(a_rem_bound, vld_ff[LAT-2] && !quo_w[QW][QW-1] && !tag_w[QW].degen, rem_w[QW] < RW'(den_w[QW]))

endmodule

@@ hdl/cmr_front.sv @@
// geometry front end: edges, triple product and sum of squared edge lengths
module cmr_front #(
   parameter int COORD_WIDTH = cmr_pkg::COORD_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            en,
   input  logic signed [COORD_WIDTH-1:0]   pt [4][3],
   output logic signed [3*COORD_WIDTH+5:0] d,
   output logic        [2*COORD_WIDTH+6:0] l
);
   import cmr_pkg::*;

   localparam int EW  = COORD_WIDTH + 1;
   localparam int PW  = 2 * EW;
   localparam int XW  = PW + 1;
   localparam int DPW = XW + EW;
   localparam int DW  = DPW + 2;
   localparam int ESW = PW + 2;
   localparam int LW  = ESW + 3;

   logic signed [EW-1:0]  g_ff   [6][3];
   logic signed [PW-1:0]  t_ff   [3];
   logic signed [PW-1:0]  u_ff   [3];
   logic        [PW-1:0]  sq_ff  [6][3];
   logic signed [EW-1:0]  e3a_ff [3];
   logic signed [XW-1:0]  c_ff   [3];
   logic        [ESW-1:0] es_ff  [6];
   logic signed [EW-1:0]  e3b_ff [3];
   logic signed [DPW-1:0] dp_ff  [3];
   logic        [LW-1:0]  l4_in;
   logic        [LW-1:0]  l4_ff;
   logic signed [DW-1:0]  d_ff;
   logic        [LW-1:0]  l5_ff;

   // stage 1: the edge vector of every point pair
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 6; i++) begin
            for (int k = 0; k < 3; k++) begin
               g_ff[i][k] <= EW'(pt[EDGE_TO[i]][k]) - EW'(pt[EDGE_FROM[i]][k]);
            end
         end
      end
   end

   // stage 2: cross product terms and squared components
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            t_ff[k]   <= g_ff[0][AXIS_NEXT[k]] * g_ff[1][AXIS_PREV[k]];
            u_ff[k]   <= g_ff[0][AXIS_PREV[k]] * g_ff[1][AXIS_NEXT[k]];
            e3a_ff[k] <= g_ff[2][k];
         end
         for (int i = 0; i < 6; i++) begin
            for (int k = 0; k < 3; k++) begin
               sq_ff[i][k] <= PW'(g_ff[i][k] * g_ff[i][k]);
            end
         end
      end
   end

   // stage 3: cross product components and squared edge lengths
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            c_ff[k]   <= XW'(t_ff[k]) - XW'(u_ff[k]);
            e3b_ff[k] <= e3a_ff[k];
         end
         for (int i = 0; i < 6; i++) begin
            es_ff[i] <= ESW'(sq_ff[i][0]) + ESW'(sq_ff[i][1]) + ESW'(sq_ff[i][2]);
         end
      end
   end

   // stage 4: dot product terms and sum of squared edge lengths
   always_comb begin
      l4_in = '0;
      for (int i = 0; i < 6; i++) begin
         l4_in = l4_in + LW'(es_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            dp_ff[k] <= c_ff[k] * e3b_ff[k];
         end
         l4_ff <= l4_in;
      end
   end

   // stage 5: six times the signed volume
   always_ff @(posedge clock) begin
      if (en) begin
         d_ff  <= DW'(dp_ff[0]) + DW'(dp_ff[1]) + DW'(dp_ff[2]);
         l5_ff <= l4_ff;
      end
   end

   assign d = d_ff;
   assign l = l5_ff;

endmodule

@@ hdl/cmr_wide_mul.sv @@
// unsigned multiplier split into chunk products over three register stages
module cmr_wide_mul #(
   parameter int A_W = 32,
   parameter int B_W = 32
) (
   input  logic               clock,
   input  logic               en,
   input  logic [A_W-1:0]     a,
   input  logic [B_W-1:0]     b,
   output logic [A_W+B_W-1:0] p
);
   import cmr_pkg::*;

   localparam int CH   = MUL_CHUNK;
   localparam int NA   = (A_W + CH - 1) / CH;
   localparam int NB   = (B_W + CH - 1) / CH;
   localparam int APW  = NA * CH;
   localparam int BPW  = NB * CH;
   localparam int PPW  = 2 * CH;
   localparam int ROWW = CH + BPW;
   localparam int PRW  = APW + BPW;

   logic [APW-1:0]  a_pad;
   logic [BPW-1:0]  b_pad;
   logic [PPW-1:0]  pp_ff  [NA][NB];
   logic [ROWW-1:0] row_in [NA];
   logic [ROWW-1:0] row_ff [NA];
   logic [PRW-1:0]  p_in;
   logic [PRW-1:0]  p_ff;

   assign a_pad = APW'(a);
   assign b_pad = BPW'(b);

   // chunk by chunk partial products
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
               pp_ff[i][j] <= PPW'(a_pad[i*CH +: CH]) * PPW'(b_pad[j*CH +: CH]);
            end
         end
      end
   end

   // one row per chunk of a
   always_comb begin
      for (int i = 0; i < NA; i++) begin
         row_in[i] = '0;
         for (int j = 0; j < NB; j++) begin
            row_in[i] = row_in[i] + (ROWW'(pp_ff[i][j]) << (j * CH));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         row_ff <= row_in;
      end
   end

   // final sum of the rows
   always_comb begin
      p_in = '0;
      for (int i = 0; i < NA; i++) begin
         p_in = p_in + (PRW'(row_ff[i]) << (i * CH));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
      end
   end

   assign p = p_ff[A_W+B_W-1:0];

endmodule

@@ hdl/cmr_div_stage.sv @@
// one restoring division step producing one quotient bit
module cmr_div_stage #(
   parameter int REM_W = 149,
   parameter int DEN_W = 117,
   parameter int SHIFT = 0
) (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic [REM_W-1:0]                     src_rem,
   input  logic [DEN_W-1:0]                     src_den,
   input  logic [cmr_pkg::QUALITY_WIDTH-1:0]    src_quo,
   input  cmr_pkg::cmr_tag_type                 src_tag,
   output logic [REM_W-1:0]                     dst_rem,
   output logic [DEN_W-1:0]                     dst_den,
   output logic [cmr_pkg::QUALITY_WIDTH-1:0]    dst_quo,
   output cmr_pkg::cmr_tag_type                 dst_tag
);
   import cmr_pkg::*;

   logic [REM_W-1:0]         trial;
   logic                     fits;
   logic [REM_W-1:0]         rem_in;
   logic [QUALITY_WIDTH-1:0] quo_in;
   logic [REM_W-1:0]         rem_ff;
   logic [DEN_W-1:0]         den_ff;
   logic [QUALITY_WIDTH-1:0] quo_ff;
   cmr_tag_type              tag_ff;

   // compare against the shifted divisor and subtract when it fits
   always_comb begin
      trial  = REM_W'(src_den) << SHIFT;
      fits   = src_rem >= trial;
      rem_in = fits ? src_rem - trial : src_rem;
      quo_in = src_quo | (QUALITY_WIDTH'(fits) << SHIFT);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         den_ff <= src_den;
         quo_ff <= quo_in;
         tag_ff <= src_tag;
      end
   end

   assign dst_rem = rem_ff;
   assign dst_den = den_ff;
   assign dst_quo = quo_ff;
   assign dst_tag = tag_ff;

endmodule

@@ tb/sv/cubic_mean_ratio_tet_quality_tb.sv @@
// testbench for the tetrahedron quality block, checked against a wide-integer predictor
module cubic_mean_ratio_tet_quality_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cmr_pkg::*;

   typedef struct {
      logic signed [15:0] c[4][3];
      bit                 drain;
   } tet_type;

   typedef struct {
      logic signed [QUALITY_WIDTH-1:0] quality;
      logic                            degenerate;
   } quality_type;

   logic clock;
   logic reset;

   cmr_req_if req_bus ();
   cmr_rsp_if rsp_bus ();

   cubic_mean_ratio_tet_quality DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   tet_type     pending_tets[$];
   quality_type expected_quality[$];
   int          errors;
   bit          req_took;
   bit          rsp_took;
   int          req_gap;
   int          rsp_stall;
   bit          req_calm;
   bit          rsp_calm;

   // clock generation
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // exact signed mean ratio of one tetrahedron
   function automatic quality_type predict_quality(tet_type t);
      logic signed [191:0] p[4][3];
      logic signed [191:0] e[3][3];
      logic signed [191:0] cr[3];
      logic signed [191:0] vol6;
      logic signed [191:0] diff;
      logic [191:0]        len_sum;
      logic [191:0]        num;
      logic [191:0]        den;
      logic [191:0]        q;
      logic [191:0]        mag;
      bit                  neg;
      quality_type         r;
      for (int i = 0; i < 4; i++)
         for (int k = 0; k < 3; k++)
            p[i][k] = 192'(t.c[i][k]);
      for (int i = 0; i < 3; i++)
         for (int k = 0; k < 3; k++)
            e[i][k] = p[i+1][k] - p[0][k];
      for (int k = 0; k < 3; k++)
         cr[k] = e[0][(k+1)%3] * e[1][(k+2)%3] - e[0][(k+2)%3] * e[1][(k+1)%3];
      vol6 = cr[0] * e[2][0] + cr[1] * e[2][1] + cr[2] * e[2][2];
      len_sum = '0;
      for (int a = 0; a < 3; a++)
         for (int b = a + 1; b < 4; b++)
            for (int k = 0; k < 3; k++) begin
               diff = p[b][k] - p[a][k];
               len_sum = len_sum + diff * diff;
            end
      if (len_sum == 0) begin
         r.quality = '0;
         r.degenerate = 1'b1;
         return r;
      end
      neg = vol6 < 0;
      mag = neg ? -vol6 : vol6;
      num = (mag * mag * 192'(432)) << QUALITY_FRAC_BITS_DEF;
      den = len_sum * len_sum * len_sum;
      q = num / den;
      if (q > MAX_MAG)
         q = MAX_MAG;
      r.quality = neg ? -q[31:0] : q[31:0];
      r.degenerate = 1'b0;
      return r;
   endfunction

   // tetrahedron built from one point and three offsets
   function automatic tet_type make_tet(int b[3], int o1[3], int o2[3], int o3[3]);
      tet_type t;
      for (int k = 0; k < 3; k++) begin
         t.c[0][k] = 16'(b[k]);
         t.c[1][k] = 16'(b[k] + o1[k]);
         t.c[2][k] = 16'(b[k] + o2[k]);
         t.c[3][k] = 16'(b[k] + o3[k]);
      end
      t.drain = 1'b0;
      return t;
   endfunction

   // random tetrahedron of a given flavor
   function automatic tet_type random_tet(int flavor);
      tet_type t;
      int      s;
      int      b[3];
      int      o1[3];
      int      o2[3];
      int      o3[3];
      t.drain = 1'b0;
      case (flavor)
         0: begin
            for (int i = 0; i < 4; i++)
               for (int k = 0; k < 3; k++)
                  t.c[i][k] = 16'($urandom);
         end
         1: begin
            for (int i = 0; i < 4; i++)
               for (int k = 0; k < 3; k++)
                  t.c[i][k] = 16'($signed($urandom_range(0, 128)) - 64);
         end
         2: begin
            // near-regular shape with jitter
            s = $urandom_range(1, 8000);
            for (int k = 0; k < 3; k++) begin
               b[k] = $signed($urandom_range(0, 16000)) - 8000;
            end
            o1 = '{2*s, 0, 0};
            o2 = '{s, 2*s - s/4, 0};
            o3 = '{s, s/2, 2*s - s/3};
            for (int k = 0; k < 3; k++) begin
               o1[k] += $signed($urandom_range(0, 40)) - 20;
               o2[k] += $signed($urandom_range(0, 40)) - 20;
               o3[k] += $signed($urandom_range(0, 40)) - 20;
            end
            if ($urandom_range(0, 1))
               t = make_tet(b, o2, o1, o3);
            else
               t = make_tet(b, o1, o2, o3);
         end
         3: begin
            // all points on one spot
            for (int k = 0; k < 3; k++)
               t.c[0][k] = 16'($urandom);
            for (int i = 1; i < 4; i++)
               t.c[i] = t.c[0];
         end
         default: begin
            // flat: apex in the plane of the base
            for (int k = 0; k < 3; k++) begin
               b[k] = $signed($urandom_range(0, 2000)) - 1000;
               o1[k] = $signed($urandom_range(0, 2000)) - 1000;
               o2[k] = $signed($urandom_range(0, 2000)) - 1000;
               o3[k] = o1[k] + o2[k];
            end
            t = make_tet(b, o1, o2, o3);
         end
      endcase
      return t;
   endfunction

   // request driver
   always @(negedge clock) begin
      if (!reset && !(req_bus.valid && !req_took)) begin
         if (req_gap > 0) begin
            req_bus.valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (pending_tets.size() > 0 &&
                      !(pending_tets[0].drain && expected_quality.size() > 0)) begin
            tet_type t;
            t = pending_tets.pop_front();
            req_bus.x0 <= t.c[0][0]; req_bus.y0 <= t.c[0][1]; req_bus.z0 <= t.c[0][2];
            req_bus.x1 <= t.c[1][0]; req_bus.y1 <= t.c[1][1]; req_bus.z1 <= t.c[1][2];
            req_bus.x2 <= t.c[2][0]; req_bus.y2 <= t.c[2][1]; req_bus.z2 <= t.c[2][2];
            req_bus.x3 <= t.c[3][0]; req_bus.y3 <= t.c[3][1]; req_bus.z3 <= t.c[3][2];
            req_bus.valid <= 1'b1;
            if ($urandom_range(0, 39) == 0)
               req_calm = !req_calm;
            req_gap <= req_calm ? 0 : $urandom_range(0, 14);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response ready with random stalls
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_took) begin
            if ($urandom_range(0, 39) == 0)
               rsp_calm = !rsp_calm;
            rsp_stall = rsp_calm ? 0 : $urandom_range(0, 14);
         end
         if (rsp_stall > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_stall = rsp_stall - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // request capture and response check
   always @(posedge clock) begin
      req_took <= req_bus.valid && req_bus.ready;
      rsp_took <= rsp_bus.valid && rsp_bus.ready;
      if (!reset && req_bus.valid && req_bus.ready) begin
         tet_type t;
         t.c[0] = '{req_bus.x0, req_bus.y0, req_bus.z0};
         t.c[1] = '{req_bus.x1, req_bus.y1, req_bus.z1};
         t.c[2] = '{req_bus.x2, req_bus.y2, req_bus.z2};
         t.c[3] = '{req_bus.x3, req_bus.y3, req_bus.z3};
         t.drain = 1'b0;
         expected_quality.push_back(predict_quality(t));
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_quality.size() == 0) begin
            errors++;
            $display("%0t: unexpected response quality=%0d degenerate=%0b",
                     $time, rsp_bus.quality, rsp_bus.degenerate);
         end else begin
            quality_type x;
            x = expected_quality.pop_front();
            if (rsp_bus.quality !== x.quality) begin
               errors++;
               $display("%0t: quality expected %0d actual %0d",
                        $time, x.quality, rsp_bus.quality);
            end
            if (rsp_bus.degenerate !== x.degenerate) begin
               errors++;
               $display("%0t: degenerate expected %0b actual %0b",
                        $time, x.degenerate, rsp_bus.degenerate);
            end
         end
      end
   end

   // stimulus and end of run
   initial begin
      tet_type t;
      int      z[3];
      reset = 1'b1;
      req_bus.valid = 1'b0;
      {req_bus.x0, req_bus.y0, req_bus.z0} = '0;
      {req_bus.x1, req_bus.y1, req_bus.z1} = '0;
      {req_bus.x2, req_bus.y2, req_bus.z2} = '0;
      {req_bus.x3, req_bus.y3, req_bus.z3} = '0;
      rsp_bus.ready = 1'b0;
      errors = 0;
      req_took = 1'b0;
      rsp_took = 1'b0;
      req_gap = 0;
      rsp_stall = 0;
      req_calm = 1'b0;
      rsp_calm = 1'b0;

      // directed: coincident points, extremes, regular shape both ways, flat
      z = '{0, 0, 0};
      pending_tets.push_back(make_tet(z, z, z, z));
      pending_tets.push_back(make_tet('{-32768, -32768, -32768}, z, z, z));
      pending_tets.push_back(make_tet('{32767, 32767, 32767}, z, z, z));
      pending_tets.push_back(make_tet('{-32768, -32768, -32768},
         '{65535, 0, 0}, '{0, 65535, 0}, '{0, 0, 65535}));
      pending_tets.push_back(make_tet('{-32768, -32768, -32768},
         '{0, 65535, 0}, '{65535, 0, 0}, '{0, 0, 65535}));
      pending_tets.push_back(make_tet('{32767, -32768, 32767},
         '{-65535, 65535, 0}, '{0, 65535, -65535}, '{-65535, 0, -65535}));
      pending_tets.push_back(make_tet('{10000, 10000, 10000},
         '{0, -20000, -20000}, '{-20000, 0, -20000}, '{-20000, -20000, 0}));
      pending_tets.push_back(make_tet('{10000, 10000, 10000},
         '{-20000, 0, -20000}, '{0, -20000, -20000}, '{-20000, -20000, 0}));
      pending_tets.push_back(make_tet('{-1, -1, -1}, '{1, 0, 0}, '{0, 1, 0}, '{0, 0, 1}));
      pending_tets.push_back(make_tet('{0, 0, 0}, '{1, 0, 0}, '{2, 0, 0}, '{3, 0, 0}));
      pending_tets.push_back(make_tet('{5, 5, 5}, '{1, 0, 0}, '{0, 1, 0}, '{1, 1, 0}));
      pending_tets.push_back(make_tet('{-32768, 32767, 0}, '{65535, 0, 0},
         '{0, -65535, 0}, '{0, 0, 32767}));
      for (int i = 0; i < 3; i++)
         pending_tets.push_back(random_tet(3));

      // random part, with a few full drains
      for (int n = 0; n < 1135; n++) begin
         int pick;
         pick = $urandom_range(0, 99);
         if (pick < 35)
            t = random_tet(0);
         else if (pick < 60)
            t = random_tet(2);
         else if (pick < 80)
            t = random_tet(1);
         else if (pick < 90)
            t = random_tet(4);
         else
            t = random_tet(3);
         t.drain = (n % 300 == 150);
         pending_tets.push_back(t);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      wait (pending_tets.size() == 0 && !req_bus.valid && expected_quality.size() == 0);
      repeat (100) @(posedge clock);
      if (errors == 0 && expected_quality.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // watchdog
   initial begin
      #6_000_000;
      $display("TEST FAILED");
      $finish;
   end
endmodule
